FILE: hw/rtl/huffman_code_builder_unit_defines.svh
// Assertion macros shared by the Huffman code builder RTL.
// Depends on nothing; included by the top level.
`ifndef HUFFMAN_CODE_BUILDER_UNIT_DEFINES_SVH
`define HUFFMAN_CODE_BUILDER_UNIT_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define HCB_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define HCB_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: hw/rtl/hcb_pkg.sv
// Package for the Huffman code builder: sizes, widths and the control types.
// Depends on nothing; used by every module of the block.
`default_nettype none
package hcb_pkg;
	localparam int NumSymbolsDef = 6;
	localparam int WeightW = 16;
	localparam int NodeWeightW = 19;
	localparam int SymbolW = 3;
	localparam int CodeBitsW = 5;
	localparam int CodeLenW = 3;

	typedef enum logic [5:0] {
		ST_LOAD  = 6'b000001,
		ST_PICKA = 6'b000010,
		ST_PICKB = 6'b000100,
		ST_MERGE = 6'b001000,
		ST_WALK  = 6'b010000,
		ST_EMIT  = 6'b100000
	} state_t;

	typedef struct packed {
		logic load;
		logic scan_start;
		logic take_a;
		logic take_b;
		logic merge;
		logic walk_start;
		logic walk_step;
		logic next_sym;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic walk_done;
		logic last_load;
		logic last_merge;
		logic last_symbol;
	} sts_t;
endpackage
`default_nettype wire

FILE: hw/rtl/huffman_code_builder_unit.sv
// Throughput: a symbol weight is taken each cycle until the last one of a set.
// Each merge round scans the live nodes twice for the two lightest, then merges them;
// after the last merge each code is found by a parent walk from its leaf and then output.
// Reset clears the controller and all live flags; the next transfer starts a set.
`default_nettype none
`include "huffman_code_builder_unit_defines.svh"
module huffman_code_builder_unit #(
	parameter int NUM_SYMBOLS = hcb_pkg::NumSymbolsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // weight[15:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // symbol[2:0], code_bits[7:3], code_length[10:8], zero
	output logic             m_tlast
);
	hcb_pkg::cmd_t                    cmd;
	hcb_pkg::sts_t                    sts;
	logic [hcb_pkg::SymbolW-1:0]      symbol;
	logic [hcb_pkg::CodeBitsW-1:0]    code_bits;
	logic [hcb_pkg::CodeLenW-1:0]     code_length;

	hcb_control u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast),
		.sts(sts), .cmd(cmd)
	);

	hcb_datapath #(.NUM_SYMBOLS(NUM_SYMBOLS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .weight(s_tdata),
		.symbol(symbol), .code_bits(code_bits), .code_length(code_length)
	);

	assign m_tdata = {5'b00000, code_length, code_bits, symbol};

	`HCB_ASSERT_IMPL(a_no_overlap, clk, arst_n, m_tvalid, !s_tready, "input open during output")
	`HCB_ASSERT_IMPL(a_len_nonzero, clk, arst_n, m_tvalid, code_length != '0, "zero code length")
	`HCB_ASSERT_NEXT(a_last_returns, clk, arst_n, m_tvalid && m_tready && m_tlast, s_tready, "not back to loading after last code")
endmodule
`default_nettype wire

FILE: hw/rtl/hcb_datapath.sv
// Datapath of the Huffman code builder: node store, lightest-node scan and code walk.
// Depends on hcb_pkg; driven by hcb_control.
`default_nettype none
module hcb_datapath #(
	parameter int NUM_SYMBOLS = hcb_pkg::NumSymbolsDef
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire hcb_pkg::cmd_t                cmd,
	output hcb_pkg::sts_t                     sts,
	input  wire logic [hcb_pkg::WeightW-1:0]  weight,
	output logic [hcb_pkg::SymbolW-1:0]       symbol,
	output logic [hcb_pkg::CodeBitsW-1:0]     code_bits,
	output logic [hcb_pkg::CodeLenW-1:0]      code_length
);
	localparam int NodeCount = 2 * NUM_SYMBOLS - 1;
	localparam int IdxW = $clog2(NodeCount);
	localparam int SymCntW = $clog2(NUM_SYMBOLS + 1);
	localparam int LenW = $clog2(NodeCount + 1);
	localparam logic [IdxW-1:0] Root = IdxW'(NodeCount - 1);

	logic [hcb_pkg::NodeWeightW-1:0] weight_q [NodeCount];
	logic [IdxW-1:0]                 parent_q [NodeCount];
	logic [NodeCount-1:0]            branch_q;
	logic [NodeCount-1:0]            live_q;
	logic [SymCntW-1:0]              count_q;
	logic [IdxW-1:0]                 lim_q;
	logic [IdxW-1:0]                 scan_q;
	logic [IdxW-1:0]                 best_q;
	logic                            found_q;
	logic [IdxW-1:0]                 a_q;
	logic [IdxW-1:0]                 sym_q;
	logic [IdxW-1:0]                 node_q;
	logic [LenW-1:0]                 len_q;
	logic [NodeCount-1:0]            bits_q;
	logic                            better;

	assign better = live_q[scan_q] &&
		(!found_q || weight_q[scan_q] < weight_q[best_q]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= '0;
			count_q <= '0;
			lim_q <= IdxW'(NUM_SYMBOLS);
			scan_q <= IdxW'(NUM_SYMBOLS);
			found_q <= 1'b0;
			sym_q <= '0;
		end else begin
			if (cmd.load) begin
				live_q[IdxW'(count_q)] <= 1'b1;
				count_q <= count_q + 1'b1;
			end
			if (cmd.scan_start) begin
				scan_q <= '0;
				found_q <= 1'b0;
			end else if (!sts.scan_done) begin
				if (better) found_q <= 1'b1;
				scan_q <= scan_q + 1'b1;
			end
			if (cmd.take_a) live_q[best_q] <= 1'b0;
			if (cmd.take_b) live_q[best_q] <= 1'b0;
			if (cmd.merge) begin
				live_q[lim_q] <= 1'b1;
				lim_q <= lim_q + 1'b1;
			end
			if (cmd.next_sym) sym_q <= sym_q + 1'b1;
			if (cmd.clear) begin
				live_q <= '0;
				count_q <= '0;
				lim_q <= IdxW'(NUM_SYMBOLS);
				scan_q <= IdxW'(NUM_SYMBOLS);
				sym_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) weight_q[IdxW'(count_q)] <= {3'b000, weight};
		if (!cmd.scan_start && !sts.scan_done && better) best_q <= scan_q;
		if (cmd.take_a) a_q <= best_q;
		if (cmd.merge) begin
			weight_q[lim_q] <= weight_q[a_q] + weight_q[best_q];
			parent_q[a_q] <= lim_q;
			branch_q[a_q] <= 1'b0;
			parent_q[best_q] <= lim_q;
			branch_q[best_q] <= 1'b1;
		end
		if (cmd.walk_start) begin
			node_q <= cmd.next_sym ? sym_q + 1'b1 : sym_q;
			len_q <= '0;
			bits_q <= '0;
		end else if (cmd.walk_step && !sts.walk_done) begin
			bits_q[len_q[IdxW-1:0]] <= branch_q[node_q];
			len_q <= len_q + 1'b1;
			node_q <= parent_q[node_q];
		end
	end

	always_comb begin
		sts.scan_done = (scan_q == lim_q);
		sts.walk_done = (node_q == Root);
		sts.last_load = (count_q == SymCntW'(NUM_SYMBOLS - 1));
		sts.last_merge = (lim_q == Root);
		sts.last_symbol = (sym_q == IdxW'(NUM_SYMBOLS - 1));
	end

	assign symbol = hcb_pkg::SymbolW'(sym_q);
	assign code_bits = hcb_pkg::CodeBitsW'(bits_q);
	assign code_length = hcb_pkg::CodeLenW'(len_q);
endmodule
`default_nettype wire

FILE: hw/rtl/hcb_control.sv
// Controller of the Huffman code builder: sequences loading, merging and code output.
// Depends on hcb_pkg; commands hcb_datapath.
`default_nettype none
module hcb_control (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic               m_tlast,
	input  wire hcb_pkg::sts_t sts,
	output hcb_pkg::cmd_t      cmd
);
	hcb_pkg::state_t state_q;
	logic            in_fire;
	logic            out_fire;

	assign s_tready = (state_q == hcb_pkg::ST_LOAD);
	assign m_tvalid = (state_q == hcb_pkg::ST_EMIT);
	assign m_tlast = sts.last_symbol;
	assign in_fire = s_tvalid && s_tready;
	assign out_fire = m_tvalid && m_tready;

	always_comb begin
		cmd = '0;
		cmd.load = in_fire;
		cmd.scan_start = (in_fire && sts.last_load) ||
			(state_q == hcb_pkg::ST_PICKA && sts.scan_done) ||
			(state_q == hcb_pkg::ST_MERGE && !sts.last_merge);
		cmd.take_a = (state_q == hcb_pkg::ST_PICKA) && sts.scan_done;
		cmd.take_b = (state_q == hcb_pkg::ST_PICKB) && sts.scan_done;
		cmd.merge = (state_q == hcb_pkg::ST_MERGE);
		cmd.walk_start = (state_q == hcb_pkg::ST_MERGE && sts.last_merge) ||
			(out_fire && !sts.last_symbol);
		cmd.walk_step = (state_q == hcb_pkg::ST_WALK);
		cmd.next_sym = out_fire && !sts.last_symbol;
		cmd.clear = out_fire && sts.last_symbol;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hcb_pkg::ST_LOAD;
		end else begin
			unique case (state_q)
				hcb_pkg::ST_LOAD: begin
					if (in_fire && sts.last_load) state_q <= hcb_pkg::ST_PICKA;
				end
				hcb_pkg::ST_PICKA: begin
					if (sts.scan_done) state_q <= hcb_pkg::ST_PICKB;
				end
				hcb_pkg::ST_PICKB: begin
					if (sts.scan_done) state_q <= hcb_pkg::ST_MERGE;
				end
				hcb_pkg::ST_MERGE: begin
					state_q <= sts.last_merge ? hcb_pkg::ST_WALK : hcb_pkg::ST_PICKA;
				end
				hcb_pkg::ST_WALK: begin
					if (sts.walk_done) state_q <= hcb_pkg::ST_EMIT;
				end
				hcb_pkg::ST_EMIT: begin
					if (out_fire)
						state_q <= sts.last_symbol ? hcb_pkg::ST_LOAD : hcb_pkg::ST_WALK;
				end
				default: state_q <= hcb_pkg::ST_LOAD;
			endcase
		end
	end
endmodule
`default_nettype wire
